// ----- design/slot_occupancy_map_min_gap_unit_macros.svh -----
// Assertion macros used by the top design file.
`ifndef SLOT_OCCUPANCY_MAP_MIN_GAP_UNIT_MACROS_SVH
`define SLOT_OCCUPANCY_MAP_MIN_GAP_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on the rising clock edge.
`define SOMG_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("somg assertion failed");
// Next-cycle implication, sampled on the rising clock edge.
`define SOMG_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("somg assertion failed");
`else
`define SOMG_ASSERT_NOW(lbl, ante, cons)
`define SOMG_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/somg_pkg.sv -----
package somg_pkg;

  localparam int NUM_SLOTS   = 128;
  localparam int MAX_ENTRIES = 32;

  // Fixed field widths of the request and result channels.
  localparam int FUNC_W  = 2;
  localparam int ID_W    = 16;
  localparam int START_W = 7;
  localparam int COUNT_W = 8;
  localparam int INDEX_W = 8;
  localparam int TAG_W   = 6;
  localparam int SUM_W   = 12;
  localparam int FLT_W   = 6;
  localparam int GAP_W   = 7;

  localparam int SLOT_AW  = $clog2(NUM_SLOTS);
  localparam int ENTRY_AW = $clog2(MAX_ENTRIES);
  localparam int CNT_W    = $clog2(MAX_ENTRIES + 1);
  localparam int ENTRY_W  = ID_W + START_W;
  localparam int GAP_CW   = $clog2(NUM_SLOTS + 1);
  localparam int GCMP_W   = (GAP_CW > GAP_W) ? GAP_CW : GAP_W;
  // A slot position must hold any start value and the row length itself.
  localparam int SPOS_W   =
    $clog2(((NUM_SLOTS > (1 << START_W)) ? NUM_SLOTS : (1 << START_W)) + 1);

  localparam logic [SUM_W-1:0] SUM_MAX = '1;
  localparam logic [GAP_W-1:0] GAP_MAX = '1;

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REMOVE = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;

  typedef struct packed {
    logic clear;
    logic step;
    logic occ;
  } gap_ctl_t;

  typedef struct packed {
    logic             found;
    logic [GAP_W-1:0] gap;
  } gap_res_t;

endpackage

// ----- design/somg_ram.sv -----
module somg_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// ----- design/somg_gap_scan.sv -----
module somg_gap_scan (
  input  logic               clk,
  input  logic               rst_n,
  input  somg_pkg::gap_ctl_t ctl,
  output somg_pkg::gap_res_t res
);

  logic                        prev_occ_r, prev_occ_nxt;
  logic                        seen_run_r, seen_run_nxt;
  logic                        have_gap_r, have_gap_nxt;
  logic [somg_pkg::GAP_CW-1:0] free_cnt_r, free_cnt_nxt;
  logic [somg_pkg::GAP_CW-1:0] best_r, best_nxt;

  // The free counter restarts on every occupied slot, so at the first slot of
  // a run it holds the length of the free stretch before that run.
  always_comb begin
    prev_occ_nxt = prev_occ_r;
    seen_run_nxt = seen_run_r;
    have_gap_nxt = have_gap_r;
    free_cnt_nxt = free_cnt_r;
    best_nxt     = best_r;
    if (ctl.clear) begin
      prev_occ_nxt = 1'b0;
      seen_run_nxt = 1'b0;
      have_gap_nxt = 1'b0;
      free_cnt_nxt = '0;
      best_nxt     = '0;
    end else if (ctl.step) begin
      if (ctl.occ) begin
        if (!prev_occ_r && seen_run_r) begin
          if (!have_gap_r || (free_cnt_r < best_r)) begin
            best_nxt = free_cnt_r;
          end
          have_gap_nxt = 1'b1;
        end
        seen_run_nxt = 1'b1;
        prev_occ_nxt = 1'b1;
        free_cnt_nxt = '0;
      end else begin
        prev_occ_nxt = 1'b0;
        free_cnt_nxt = free_cnt_r + somg_pkg::GAP_CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_occ_r <= 1'b0;
      seen_run_r <= 1'b0;
      have_gap_r <= 1'b0;
    end else begin
      prev_occ_r <= prev_occ_nxt;
      seen_run_r <= seen_run_nxt;
      have_gap_r <= have_gap_nxt;
    end
    free_cnt_r <= free_cnt_nxt;
    best_r     <= best_nxt;
  end

  always_comb begin
    res.found = have_gap_r;
    if (somg_pkg::GCMP_W'(best_r) > somg_pkg::GCMP_W'(somg_pkg::GAP_MAX)) begin
      res.gap = somg_pkg::GAP_MAX;
    end else begin
      res.gap = somg_pkg::GAP_W'(best_r);
    end
  end

endmodule

// ----- design/slot_occupancy_map_min_gap_unit.sv -----
// Steps per request: dispatch, then for a remove, or an add while the table is not full, a
// search of the whole entry table and an apply step, with a fill of n slots (at most 128) when
// an add succeeds or a remove finds its id; an in-range read captures one slot. With fewer
// than two reservations the slot row scan is skipped. One request at a time: the next is
// taken once the result is registered and the previous one has been accepted.
// Reset: control state clears at once, then a pass zeroes the slot memory.
`include "slot_occupancy_map_min_gap_unit_macros.svh"

module slot_occupancy_map_min_gap_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [somg_pkg::FUNC_W-1:0]  in_func,
  input  logic [somg_pkg::ID_W-1:0]    in_flight_id,
  input  logic [somg_pkg::START_W-1:0] in_start_slot,
  input  logic [somg_pkg::COUNT_W-1:0] in_slot_count,
  input  logic [somg_pkg::INDEX_W-1:0] in_slot_index,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         out_op_ok,
  output logic [somg_pkg::TAG_W-1:0]   out_slot_value,
  output logic                         out_slot_in_range,
  output logic [somg_pkg::SUM_W-1:0]   out_occupied_total,
  output logic [somg_pkg::FLT_W-1:0]   out_flight_total,
  output logic [somg_pkg::GAP_W-1:0]   out_min_gap,
  output logic                         out_min_gap_valid
);

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISP,
    S_SRCH,
    S_SRCH_END,
    S_APPLY,
    S_FILL,
    S_RDCAP,
    S_GAP_START,
    S_GAP_SCAN,
    S_GAP_END,
    S_WRAP
  } state_t;

  state_t state_r, state_nxt;

  logic [somg_pkg::SPOS_W-1:0]   pos_r, pos_nxt;
  logic [somg_pkg::COUNT_W-1:0]  left_r, left_nxt;
  logic [somg_pkg::TAG_W-1:0]    tag_r, tag_nxt;
  logic [somg_pkg::ENTRY_AW-1:0] ent_idx_r, ent_idx_nxt;
  logic                          chk_vld_r, chk_vld_nxt;
  logic [somg_pkg::ENTRY_AW-1:0] chk_idx_r, chk_idx_nxt;
  logic                          hit_r, hit_nxt;
  logic [somg_pkg::ENTRY_AW-1:0] hit_idx_r, hit_idx_nxt;
  logic [somg_pkg::START_W-1:0]  hit_start_r, hit_start_nxt;
  logic                          free_r, free_nxt;
  logic [somg_pkg::ENTRY_AW-1:0] free_idx_r, free_idx_nxt;
  logic [somg_pkg::MAX_ENTRIES-1:0] entry_valid_r, entry_valid_nxt;
  logic [somg_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [somg_pkg::SUM_W-1:0]    sum_r, sum_nxt;
  logic                          scan_vld_r, scan_vld_nxt;

  logic [somg_pkg::FUNC_W-1:0]   func_r, func_nxt;
  logic [somg_pkg::ID_W-1:0]     id_r, id_nxt;
  logic [somg_pkg::START_W-1:0]  start_r, start_nxt;
  logic [somg_pkg::COUNT_W-1:0]  count_r, count_nxt;
  logic [somg_pkg::INDEX_W-1:0]  index_r, index_nxt;
  logic                          ok_r, ok_nxt;
  logic [somg_pkg::TAG_W-1:0]    value_r, value_nxt;
  logic                          in_range_r, in_range_nxt;

  logic                          out_valid_r, out_valid_nxt;
  logic                          out_ok_r, out_ok_nxt;
  logic [somg_pkg::TAG_W-1:0]    out_value_r, out_value_nxt;
  logic                          out_in_range_r, out_in_range_nxt;
  logic [somg_pkg::SUM_W-1:0]    out_sum_r, out_sum_nxt;
  logic [somg_pkg::FLT_W-1:0]    out_flt_r, out_flt_nxt;
  logic [somg_pkg::GAP_W-1:0]    out_gap_r, out_gap_nxt;
  logic                          out_gap_ok_r, out_gap_ok_nxt;

  logic                          slot_we;
  logic [somg_pkg::SLOT_AW-1:0]  slot_waddr;
  logic [somg_pkg::TAG_W-1:0]    slot_wdata;
  logic                          slot_re;
  logic [somg_pkg::SLOT_AW-1:0]  slot_raddr;
  logic [somg_pkg::TAG_W-1:0]    slot_rdata;

  logic                          tbl_we;
  logic [somg_pkg::ENTRY_AW-1:0] tbl_waddr;
  logic [somg_pkg::ENTRY_W-1:0]  tbl_wdata;
  logic                          tbl_re;
  logic [somg_pkg::ENTRY_AW-1:0] tbl_raddr;
  logic [somg_pkg::ENTRY_W-1:0]  tbl_rdata;

  somg_pkg::gap_ctl_t            gap_ctl;
  somg_pkg::gap_res_t            gap_res;

  logic [somg_pkg::SUM_W:0]      sum_add;
  logic [somg_pkg::ENTRY_AW-1:0] add_tgt;
  logic [somg_pkg::CNT_W-1:0]    cnt_inc;
  logic                          idx_in_range;
  logic                          gap_ok;

  somg_ram #(
    .WIDTH(somg_pkg::TAG_W),
    .DEPTH(somg_pkg::NUM_SLOTS)
  ) u_slot_ram (
    .clk  (clk),
    .we   (slot_we),
    .waddr(slot_waddr),
    .wdata(slot_wdata),
    .re   (slot_re),
    .raddr(slot_raddr),
    .rdata(slot_rdata)
  );

  somg_ram #(
    .WIDTH(somg_pkg::ENTRY_W),
    .DEPTH(somg_pkg::MAX_ENTRIES)
  ) u_tbl_ram (
    .clk  (clk),
    .we   (tbl_we),
    .waddr(tbl_waddr),
    .wdata(tbl_wdata),
    .re   (tbl_re),
    .raddr(tbl_raddr),
    .rdata(tbl_rdata)
  );

  somg_gap_scan u_gap_scan (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (gap_ctl),
    .res  (gap_res)
  );

  assign sum_add = {1'b0, sum_r} + (somg_pkg::SUM_W + 1)'(count_r);
  assign cnt_inc = cnt_r + somg_pkg::CNT_W'(1);
  assign add_tgt = hit_r ? hit_idx_r : free_idx_r;
  assign idx_in_range =
    somg_pkg::SPOS_W'(index_r) < somg_pkg::SPOS_W'(somg_pkg::NUM_SLOTS);
  assign gap_ok = (cnt_r > somg_pkg::CNT_W'(1)) && gap_res.found;

  always_comb begin
    state_nxt       = state_r;
    pos_nxt         = pos_r;
    left_nxt        = left_r;
    tag_nxt         = tag_r;
    ent_idx_nxt     = ent_idx_r;
    chk_vld_nxt     = 1'b0;
    chk_idx_nxt     = chk_idx_r;
    hit_nxt         = hit_r;
    hit_idx_nxt     = hit_idx_r;
    hit_start_nxt   = hit_start_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    entry_valid_nxt = entry_valid_r;
    cnt_nxt         = cnt_r;
    sum_nxt         = sum_r;
    scan_vld_nxt    = 1'b0;
    func_nxt        = func_r;
    id_nxt          = id_r;
    start_nxt       = start_r;
    count_nxt       = count_r;
    index_nxt       = index_r;
    ok_nxt          = ok_r;
    value_nxt       = value_r;
    in_range_nxt    = in_range_r;

    out_valid_nxt    = out_valid_r;
    out_ok_nxt       = out_ok_r;
    out_value_nxt    = out_value_r;
    out_in_range_nxt = out_in_range_r;
    out_sum_nxt      = out_sum_r;
    out_flt_nxt      = out_flt_r;
    out_gap_nxt      = out_gap_r;
    out_gap_ok_nxt   = out_gap_ok_r;

    slot_we    = 1'b0;
    slot_waddr = pos_r[somg_pkg::SLOT_AW-1:0];
    slot_wdata = tag_r;
    slot_re    = 1'b0;
    slot_raddr = pos_r[somg_pkg::SLOT_AW-1:0];
    tbl_we     = 1'b0;
    tbl_waddr  = add_tgt;
    tbl_wdata  = {id_r, start_r};
    tbl_re     = 1'b0;
    tbl_raddr  = ent_idx_r;

    gap_ctl.clear = 1'b0;
    gap_ctl.step  = scan_vld_r;
    gap_ctl.occ   = (slot_rdata != '0);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Table data comes back in the cycle after its read; keep the first live
    // match and the first free entry.
    if (chk_vld_r) begin
      if (entry_valid_r[chk_idx_r]) begin
        if (!hit_r && (tbl_rdata[somg_pkg::ENTRY_W-1:somg_pkg::START_W] == id_r)) begin
          hit_nxt       = 1'b1;
          hit_idx_nxt   = chk_idx_r;
          hit_start_nxt = tbl_rdata[somg_pkg::START_W-1:0];
        end
      end else if (!free_r) begin
        free_nxt     = 1'b1;
        free_idx_nxt = chk_idx_r;
      end
    end

    unique case (state_r)
      S_CLEAR: begin
        slot_we    = 1'b1;
        slot_wdata = '0;
        pos_nxt    = pos_r + somg_pkg::SPOS_W'(1);
        if (pos_r == somg_pkg::SPOS_W'(somg_pkg::NUM_SLOTS - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          func_nxt     = in_func;
          id_nxt       = in_flight_id;
          start_nxt    = in_start_slot;
          count_nxt    = in_slot_count;
          index_nxt    = in_slot_index;
          ok_nxt       = 1'b0;
          value_nxt    = '0;
          in_range_nxt = 1'b0;
          state_nxt    = S_DISP;
        end
      end
      S_DISP: begin
        hit_nxt     = 1'b0;
        free_nxt    = 1'b0;
        ent_idx_nxt = '0;
        unique case (func_r)
          somg_pkg::FUNC_ADD: begin
            if (cnt_r < somg_pkg::CNT_W'(somg_pkg::MAX_ENTRIES)) begin
              state_nxt = S_SRCH;
            end else begin
              state_nxt = S_GAP_START;
            end
          end
          somg_pkg::FUNC_REMOVE: begin
            state_nxt = S_SRCH;
          end
          somg_pkg::FUNC_READ: begin
            ok_nxt = 1'b1;
            if (idx_in_range) begin
              in_range_nxt = 1'b1;
              slot_re      = 1'b1;
              slot_raddr   = somg_pkg::SLOT_AW'(index_r);
              state_nxt    = S_RDCAP;
            end else begin
              state_nxt = S_GAP_START;
            end
          end
          default: begin
            state_nxt = S_GAP_START;
          end
        endcase
      end
      S_SRCH: begin
        tbl_re      = 1'b1;
        chk_vld_nxt = 1'b1;
        chk_idx_nxt = ent_idx_r;
        ent_idx_nxt = ent_idx_r + somg_pkg::ENTRY_AW'(1);
        if (ent_idx_r == somg_pkg::ENTRY_AW'(somg_pkg::MAX_ENTRIES - 1)) begin
          state_nxt = S_SRCH_END;
        end
      end
      S_SRCH_END: begin
        state_nxt = S_APPLY;
      end
      S_APPLY: begin
        state_nxt = S_GAP_START;
        if (func_r == somg_pkg::FUNC_ADD) begin
          if (hit_r || free_r) begin
            tbl_we                   = 1'b1;
            entry_valid_nxt[add_tgt] = 1'b1;
            cnt_nxt                  = cnt_inc;
            tag_nxt                  = somg_pkg::TAG_W'(cnt_inc);
            sum_nxt = sum_add[somg_pkg::SUM_W] ? somg_pkg::SUM_MAX
                                               : sum_add[somg_pkg::SUM_W-1:0];
            pos_nxt   = somg_pkg::SPOS_W'(start_r);
            left_nxt  = count_r;
            ok_nxt    = 1'b1;
            state_nxt = S_FILL;
          end
        end else if (hit_r) begin
          entry_valid_nxt[hit_idx_r] = 1'b0;
          if (cnt_r != '0) begin
            cnt_nxt = cnt_r - somg_pkg::CNT_W'(1);
          end
          if (sum_r > somg_pkg::SUM_W'(count_r)) begin
            sum_nxt = sum_r - somg_pkg::SUM_W'(count_r);
          end else begin
            sum_nxt = '0;
          end
          tag_nxt   = '0;
          pos_nxt   = somg_pkg::SPOS_W'(hit_start_r);
          left_nxt  = count_r;
          ok_nxt    = 1'b1;
          state_nxt = S_FILL;
        end
      end
      S_FILL: begin
        // Slots past the end of the row are dropped.
        if ((left_r != '0) &&
            (pos_r < somg_pkg::SPOS_W'(somg_pkg::NUM_SLOTS))) begin
          slot_we  = 1'b1;
          pos_nxt  = pos_r + somg_pkg::SPOS_W'(1);
          left_nxt = left_r - somg_pkg::COUNT_W'(1);
        end else begin
          state_nxt = S_GAP_START;
        end
      end
      S_RDCAP: begin
        value_nxt = slot_rdata;
        state_nxt = S_GAP_START;
      end
      S_GAP_START: begin
        gap_ctl.clear = 1'b1;
        pos_nxt       = '0;
        if (cnt_r > somg_pkg::CNT_W'(1)) begin
          state_nxt = S_GAP_SCAN;
        end else begin
          state_nxt = S_WRAP;
        end
      end
      S_GAP_SCAN: begin
        slot_re      = 1'b1;
        scan_vld_nxt = 1'b1;
        pos_nxt      = pos_r + somg_pkg::SPOS_W'(1);
        if (pos_r == somg_pkg::SPOS_W'(somg_pkg::NUM_SLOTS - 1)) begin
          state_nxt = S_GAP_END;
        end
      end
      S_GAP_END: begin
        state_nxt = S_WRAP;
      end
      S_WRAP: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt    = 1'b1;
          out_ok_nxt       = ok_r;
          out_value_nxt    = value_r;
          out_in_range_nxt = in_range_r;
          out_sum_nxt      = sum_r;
          out_flt_nxt      = somg_pkg::FLT_W'(cnt_r);
          out_gap_nxt      = gap_ok ? gap_res.gap : '0;
          out_gap_ok_nxt   = gap_ok;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_CLEAR;
      pos_r         <= '0;
      chk_vld_r     <= 1'b0;
      hit_r         <= 1'b0;
      free_r        <= 1'b0;
      entry_valid_r <= '0;
      cnt_r         <= '0;
      sum_r         <= '0;
      scan_vld_r    <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      pos_r         <= pos_nxt;
      chk_vld_r     <= chk_vld_nxt;
      hit_r         <= hit_nxt;
      free_r        <= free_nxt;
      entry_valid_r <= entry_valid_nxt;
      cnt_r         <= cnt_nxt;
      sum_r         <= sum_nxt;
      scan_vld_r    <= scan_vld_nxt;
      out_valid_r   <= out_valid_nxt;
    end
    left_r         <= left_nxt;
    tag_r          <= tag_nxt;
    ent_idx_r      <= ent_idx_nxt;
    chk_idx_r      <= chk_idx_nxt;
    hit_idx_r      <= hit_idx_nxt;
    hit_start_r    <= hit_start_nxt;
    free_idx_r     <= free_idx_nxt;
    func_r         <= func_nxt;
    id_r           <= id_nxt;
    start_r        <= start_nxt;
    count_r        <= count_nxt;
    index_r        <= index_nxt;
    ok_r           <= ok_nxt;
    value_r        <= value_nxt;
    in_range_r     <= in_range_nxt;
    out_ok_r       <= out_ok_nxt;
    out_value_r    <= out_value_nxt;
    out_in_range_r <= out_in_range_nxt;
    out_sum_r      <= out_sum_nxt;
    out_flt_r      <= out_flt_nxt;
    out_gap_r      <= out_gap_nxt;
    out_gap_ok_r   <= out_gap_ok_nxt;
  end

  assign in_ready           = (state_r == S_IDLE);
  assign out_valid          = out_valid_r;
  assign out_op_ok          = out_ok_r;
  assign out_slot_value     = out_value_r;
  assign out_slot_in_range  = out_in_range_r;
  assign out_occupied_total = out_sum_r;
  assign out_flight_total   = out_flt_r;
  assign out_min_gap        = out_gap_r;
  assign out_min_gap_valid  = out_gap_ok_r;

  // The slot memory is written only by the reset clear pass and by range fills.
  `SOMG_ASSERT_NOW(a_slot_write_src, slot_we, (state_r == S_CLEAR) || (state_r == S_FILL))
  // Duplicate adds can push the count above the live entries, never below.
  `SOMG_ASSERT_NOW(a_count_covers_entries, 1'b1, $countones(entry_valid_r) <= cnt_r)
  // A gap between two runs is at least one free slot.
  `SOMG_ASSERT_NOW(a_gap_nonzero, out_valid && out_min_gap_valid, out_min_gap != '0)
  // A request always starts with dispatch on the following cycle.
  `SOMG_ASSERT_NEXT(a_accept_dispatch, in_valid && in_ready, state_r == S_DISP)

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps

module tb;
  import somg_pkg::*;

  localparam logic [FUNC_W-1:0] FUNC_NONE = 2'd3;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int HOLD_CYCLES = 1500;
  localparam int SETTLE_CYCLES = 450;

  typedef struct packed {
    logic               op_ok;
    logic [TAG_W-1:0]   slot_value;
    logic               slot_in_range;
    logic [SUM_W-1:0]   occupied_total;
    logic [FLT_W-1:0]   flight_total;
    logic [GAP_W-1:0]   min_gap;
    logic               min_gap_valid;
  } slot_status_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [FUNC_W-1:0]   in_func;
  logic [ID_W-1:0]     in_flight_id;
  logic [START_W-1:0]  in_start_slot;
  logic [COUNT_W-1:0]  in_slot_count;
  logic [INDEX_W-1:0]  in_slot_index;
  logic                out_valid;
  logic                out_ready;
  logic                out_op_ok;
  logic [TAG_W-1:0]    out_slot_value;
  logic                out_slot_in_range;
  logic [SUM_W-1:0]    out_occupied_total;
  logic [FLT_W-1:0]    out_flight_total;
  logic [GAP_W-1:0]    out_min_gap;
  logic                out_min_gap_valid;

  // Predicted state of the slot row and the reservation table.
  logic [TAG_W-1:0]    slot_tag [NUM_SLOTS];
  logic [ID_W-1:0]     ent_id [MAX_ENTRIES];
  logic [START_W-1:0]  ent_start [MAX_ENTRIES];
  bit                  ent_valid [MAX_ENTRIES];
  int                  occ_sum;
  int                  res_count;

  slot_status_t        status_q [$];
  slot_status_t        head_status;
  logic [ID_W-1:0]     live_ids [$];
  logic [COUNT_W-1:0]  live_counts [$];
  int                  mismatches;
  int                  cycle_count;
  bit                  steady_mode;
  bit                  hold_pending;

  slot_occupancy_map_min_gap_unit DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_func           (in_func),
    .in_flight_id      (in_flight_id),
    .in_start_slot     (in_start_slot),
    .in_slot_count     (in_slot_count),
    .in_slot_index     (in_slot_index),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_op_ok         (out_op_ok),
    .out_slot_value    (out_slot_value),
    .out_slot_in_range (out_slot_in_range),
    .out_occupied_total(out_occupied_total),
    .out_flight_total  (out_flight_total),
    .out_min_gap       (out_min_gap),
    .out_min_gap_valid (out_min_gap_valid)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic void fill_slots(int first, int n, logic [TAG_W-1:0] tag);
    int k;
    for (k = 0; k < n; k++) begin
      if (first + k < NUM_SLOTS) slot_tag[SLOT_AW'(first + k)] = tag;
    end
  endfunction

  // Applies one request to the predicted state and returns the status it reports.
  function automatic slot_status_t predict_request(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                                                   logic [START_W-1:0] st,
                                                   logic [COUNT_W-1:0] cnt,
                                                   logic [INDEX_W-1:0] idx);
    slot_status_t r;
    int hit, spare, k, pos, run_start, prev_end, best;
    bit have_prev, have_gap;
    r = '0;
    case (f)
      FUNC_ADD: begin
        if (res_count < MAX_ENTRIES) begin
          hit = -1;
          spare = -1;
          for (k = 0; k < MAX_ENTRIES; k++) begin
            if (ent_valid[ENTRY_AW'(k)] && ent_id[ENTRY_AW'(k)] == id && hit < 0) hit = k;
            if (!ent_valid[ENTRY_AW'(k)] && spare < 0) spare = k;
          end
          if (hit < 0) hit = spare;
          if (hit >= 0) begin
            ent_valid[ENTRY_AW'(hit)] = 1'b1;
            ent_id[ENTRY_AW'(hit)] = id;
            ent_start[ENTRY_AW'(hit)] = st;
            res_count++;
            fill_slots(int'(st), int'(cnt), TAG_W'(res_count));
            occ_sum += int'(cnt);
            if (occ_sum > int'(SUM_MAX)) occ_sum = int'(SUM_MAX);
            r.op_ok = 1'b1;
          end
        end
      end
      FUNC_REMOVE: begin
        for (k = 0; k < MAX_ENTRIES; k++) begin
          if (ent_valid[ENTRY_AW'(k)] && ent_id[ENTRY_AW'(k)] == id) begin
            fill_slots(int'(ent_start[ENTRY_AW'(k)]), int'(cnt), '0);
            occ_sum = (occ_sum > int'(cnt)) ? occ_sum - int'(cnt) : 0;
            ent_valid[ENTRY_AW'(k)] = 1'b0;
            if (res_count > 0) res_count--;
            r.op_ok = 1'b1;
            break;
          end
        end
      end
      FUNC_READ: begin
        r.op_ok = 1'b1;
        if (int'(idx) < NUM_SLOTS) begin
          r.slot_in_range = 1'b1;
          r.slot_value = slot_tag[idx[SLOT_AW-1:0]];
        end
      end
      default: ;
    endcase

    // The gap is measured between the end of one occupied run and the start of the next.
    if (res_count > 1) begin
      pos = 0;
      prev_end = 0;
      best = 0;
      have_prev = 1'b0;
      have_gap = 1'b0;
      while (pos < NUM_SLOTS) begin
        if (slot_tag[SLOT_AW'(pos)] != '0) begin
          run_start = pos;
          while (pos < NUM_SLOTS && slot_tag[SLOT_AW'(pos)] != '0) pos++;
          if (have_prev) begin
            if (!have_gap || run_start - prev_end < best) best = run_start - prev_end;
            have_gap = 1'b1;
          end
          prev_end = pos;
          have_prev = 1'b1;
        end else begin
          pos++;
        end
      end
      if (have_gap) begin
        r.min_gap_valid = 1'b1;
        r.min_gap = (best > int'(GAP_MAX)) ? GAP_MAX : GAP_W'(best);
      end
    end
    r.occupied_total = SUM_W'(occ_sum);
    r.flight_total = FLT_W'(res_count);
    return r;
  endfunction

  function automatic int find_live(logic [ID_W-1:0] id);
    foreach (live_ids[k]) begin
      if (live_ids[k] == id) return k;
    end
    return -1;
  endfunction

  function automatic logic [ID_W-1:0] fresh_id();
    logic [ID_W-1:0] id;
    do id = ID_W'($urandom_range(0, 65535)); while (find_live(id) >= 0);
    return id;
  endfunction

  // Mostly short reservations, some long ones and now and then the full row.
  function automatic logic [COUNT_W-1:0] rnd_count();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return COUNT_W'($urandom_range(0, 12));
    if (pick < 95) return COUNT_W'($urandom_range(13, 127));
    return COUNT_W'(NUM_SLOTS);
  endfunction

  task automatic send_request(input logic [FUNC_W-1:0] f, input logic [ID_W-1:0] id,
                              input logic [START_W-1:0] st, input logic [COUNT_W-1:0] cnt,
                              input logic [INDEX_W-1:0] idx, output bit ok);
    int gap_cycles;
    slot_status_t want;
    @(negedge clk);
    gap_cycles = 0;
    if (!steady_mode) begin
      while ($urandom_range(0, 99) < 21) gap_cycles++;
    end
    if (gap_cycles > 0) begin
      in_valid = 1'b0;
      repeat (gap_cycles) @(negedge clk);
    end
    in_valid = 1'b1;
    in_func = f;
    in_flight_id = id;
    in_start_slot = st;
    in_slot_count = cnt;
    in_slot_index = idx;
    do @(posedge clk); while (!in_ready);
    want = predict_request(f, id, st, cnt, idx);
    status_q.insert(status_q.size(), want);
    ok = want.op_ok;
  endtask

  task automatic read_slot(input logic [INDEX_W-1:0] idx);
    bit ok;
    send_request(FUNC_READ, ID_W'($urandom_range(0, 65535)),
                 START_W'($urandom_range(0, 127)), rnd_count(), idx, ok);
  endtask

  task automatic add_reservation(input logic [ID_W-1:0] id, input logic [START_W-1:0] st,
                                 input logic [COUNT_W-1:0] cnt);
    bit ok;
    int pos;
    send_request(FUNC_ADD, id, st, cnt, INDEX_W'($urandom_range(0, 255)), ok);
    if (ok) begin
      pos = find_live(id);
      if (pos < 0) begin
        live_ids.insert(live_ids.size(), id);
        live_counts.insert(live_counts.size(), cnt);
      end else begin
        live_counts[pos] = cnt;
      end
    end
  endtask

  task automatic remove_reservation(input logic [ID_W-1:0] id, input logic [COUNT_W-1:0] cnt);
    bit ok;
    int pos;
    send_request(FUNC_REMOVE, id, START_W'($urandom_range(0, 127)), cnt,
                 INDEX_W'($urandom_range(0, 255)), ok);
    pos = find_live(id);
    if (ok && pos >= 0) begin
      live_ids.delete(pos);
      live_counts.delete(pos);
    end
  endtask

  task automatic send_random_op();
    int pick, sel, add_limit;
    logic [ID_W-1:0] id;
    logic [COUNT_W-1:0] cnt;
    bit ok;
    pick = $urandom_range(0, 99);
    // Lean toward removes as the table fills so that adds keep getting through.
    add_limit = (res_count > 20) ? 45 : 65;
    if (pick < 5) begin
      send_request(FUNC_NONE, ID_W'($urandom_range(0, 65535)),
                   START_W'($urandom_range(0, 127)), rnd_count(),
                   INDEX_W'($urandom_range(0, 255)), ok);
    end else if (pick < 30) begin
      if ($urandom_range(0, 3) == 0) read_slot(INDEX_W'($urandom_range(0, 255)));
      else read_slot(INDEX_W'($urandom_range(0, 127)));
    end else if (pick < add_limit || live_ids.size() == 0) begin
      id = fresh_id();
      if (live_ids.size() > 0 && $urandom_range(0, 49) == 0)
        id = live_ids[$urandom_range(0, live_ids.size() - 1)];
      add_reservation(id, START_W'($urandom_range(0, 127)), rnd_count());
    end else begin
      if ($urandom_range(0, 9) == 0) begin
        id = ID_W'($urandom_range(0, 65535));
        cnt = rnd_count();
      end else begin
        sel = $urandom_range(0, live_ids.size() - 1);
        id = live_ids[sel];
        cnt = ($urandom_range(0, 4) == 0) ? rnd_count() : live_counts[sel];
      end
      remove_reservation(id, cnt);
    end
  endtask

  task automatic drain_pending();
    @(negedge clk);
    in_valid = 1'b0;
    while (status_q.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    bit ok;
    read_slot(8'd0);
    read_slot(8'd127);
    read_slot(8'd128);
    read_slot(8'd255);
    send_request(FUNC_NONE, 16'hFFFF, 7'h7F, 8'd128, 8'hFF, ok);
    remove_reservation(16'hABCD, 8'd4);
    add_reservation(16'h0000, 7'd0, 8'd0);
    // Runs past the end of the row, so only the last slot is written.
    add_reservation(16'hFFFF, 7'd127, 8'd128);
    add_reservation(16'h1234, 7'd10, 8'd5);
    // Adjacent to the previous one, so the two merge into one occupied run.
    add_reservation(16'h1235, 7'd15, 8'd3);
    add_reservation(16'h2000, 7'd19, 8'd4);
    read_slot(8'd10);
    read_slot(8'd15);
    read_slot(8'd19);
    read_slot(8'd127);
    // Same id again: the entry moves, the count still grows.
    add_reservation(16'h1234, 7'd40, 8'd2);
    read_slot(8'd40);
    remove_reservation(16'h1234, 8'd2);
    remove_reservation(16'hFFFF, 8'd128);
    // Clears far more than is occupied, so the total bottoms out at zero.
    remove_reservation(16'h0000, 8'd100);
    read_slot(8'd12);
    remove_reservation(16'h1235, 8'd3);
    remove_reservation(16'h2000, 8'd4);
  endtask

  task automatic test_table_full();
    int k;
    while (res_count < MAX_ENTRIES)
      add_reservation(fresh_id(), START_W'($urandom_range(0, 127)), 8'd128);
    add_reservation(fresh_id(), START_W'($urandom_range(0, 127)), rnd_count());
    add_reservation(live_ids[0], START_W'($urandom_range(0, 127)), rnd_count());
    read_slot(INDEX_W'($urandom_range(0, 127)));
    // Free one entry without lowering the total, then push the total past its ceiling.
    for (k = 0; k < 2; k++) begin
      remove_reservation(live_ids[0], 8'd0);
      add_reservation(fresh_id(), START_W'($urandom_range(0, 127)), 8'd128);
    end
    while (live_ids.size() > 0) begin
      if ($urandom_range(0, 1) == 0) remove_reservation(live_ids[0], 8'd128);
      else remove_reservation(live_ids[0], rnd_count());
    end
  endtask

  task automatic test_backpressure();
    hold_pending = 1'b1;
    repeat (6) send_random_op();
  endtask

  task automatic test_random_mix(input int n);
    repeat (n) send_random_op();
  endtask

  task automatic test_steady_stream(input int n);
    steady_mode = 1'b1;
    repeat (n) send_random_op();
    steady_mode = 1'b0;
  endtask

  task automatic compare_field(input string field, input int want, input int got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (status_q.size() == 0) begin
        mismatches++;
        $display("%0t: result with no request pending", $time);
      end else begin
        head_status = status_q.pop_front();
        compare_field("op_ok", int'(head_status.op_ok), int'(out_op_ok));
        compare_field("slot_value", int'(head_status.slot_value), int'(out_slot_value));
        compare_field("slot_in_range", int'(head_status.slot_in_range),
                      int'(out_slot_in_range));
        compare_field("occupied_total", int'(head_status.occupied_total),
                      int'(out_occupied_total));
        compare_field("flight_total", int'(head_status.flight_total),
                      int'(out_flight_total));
        compare_field("min_gap", int'(head_status.min_gap), int'(out_min_gap));
        compare_field("min_gap_valid", int'(head_status.min_gap_valid),
                      int'(out_min_gap_valid));
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_pending) begin
        out_ready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_pending = 1'b0;
      end else begin
        out_ready = steady_mode || ($urandom_range(0, 99) >= 21);
      end
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) @(posedge clk) cycle_count++;
    $display("status: fail");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_func = FUNC_ADD;
    in_flight_id = '0;
    in_start_slot = '0;
    in_slot_count = '0;
    in_slot_index = '0;
    mismatches = 0;
    steady_mode = 1'b0;
    hold_pending = 1'b0;
    occ_sum = 0;
    res_count = 0;
    slot_tag = '{default: '0};
    ent_id = '{default: '0};
    ent_start = '{default: '0};
    ent_valid = '{default: 1'b0};
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_table_full();
    drain_pending();
    test_backpressure();
    drain_pending();
    test_random_mix(650);
    drain_pending();
    test_steady_stream(100);
    drain_pending();
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
